// ===== sv/ffbp_pkg.sv =====
package ffbp_pkg;

    localparam int FIELD_W_WEIGHT = 16;
    localparam int FIELD_W_VALUE  = 16;
    localparam int FIELD_W_INDEX  = 6;
    localparam int FIELD_W_TOTAL  = 24;
    localparam int FIELD_W_COUNT  = 7;

    localparam logic [FIELD_W_TOTAL-1:0] VALUE_MAX = 24'hFFFFFF;
    localparam logic [15:0] CAPACITY_RESET = 16'd2560;

    localparam logic [1:0] PLACE_OK       = 2'd0;
    localparam logic [1:0] PLACE_TOO_HEAVY = 2'd1;
    localparam logic [1:0] PLACE_NO_BIN   = 2'd2;

    typedef struct packed {
        logic                      start_new_set;
        logic [FIELD_W_WEIGHT-1:0] item_weight;
        logic [FIELD_W_VALUE-1:0]  item_value;
    } t_item;

    typedef struct packed {
        logic [1:0]                place_status;
        logic [FIELD_W_INDEX-1:0]  bin_index;
        logic                      opened_new_bin;
        logic [FIELD_W_WEIGHT-1:0] bin_fill_after;
        logic [FIELD_W_TOTAL-1:0]  bin_value_after;
        logic [FIELD_W_COUNT-1:0]  bins_in_use;
    } t_result;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic heavy;
        logic hit;
        logic exhausted;
    } t_dp_stat;

endpackage

// ===== sv/ffbp_ctrl.sv =====
module ffbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ffbp_pkg::t_dp_stat i_stat,
    output ffbp_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    ffbp_pkg::t_state r_state;
    ffbp_pkg::t_state n_state;
    logic             r_done;
    logic             n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffbp_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_done       = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ffbp_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ffbp_pkg::S_SCAN;
                end
            end
            ffbp_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.heavy || i_stat.hit || i_stat.exhausted) begin
                    o_cmd.finish = 1'b1;
                    n_done       = 1'b1;
                    n_state      = ffbp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffbp_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ffbp_pkg::S_IDLE);
    assign o_done = r_done;

endmodule

// ===== sv/ffbp_datapath.sv =====
module ffbp_datapath #(
    parameter int MAX_BINS    = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffbp_pkg::t_dp_cmd  i_cmd,
    input  ffbp_pkg::t_item    i_item,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output ffbp_pkg::t_dp_stat o_stat,
    output ffbp_pkg::t_result  o_result
);

    localparam int WB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int VAL_W = ffbp_pkg::FIELD_W_TOTAL;

    logic [WB-1:0]    fill_mem [MAX_BINS];
    logic [VAL_W-1:0] val_mem  [MAX_BINS];

    logic [15:0]      r_cap;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd_addr;
    logic             r_dv;
    logic [BIN_W-1:0] r_dv_idx;
    logic             r_heavy;
    logic [WB-1:0]    r_weight;
    logic [15:0]      r_value;
    logic [WB-1:0]    r_rd_fill;
    logic [VAL_W-1:0] r_rd_val;
    ffbp_pkg::t_result r_result;
    ffbp_pkg::t_result n_result;
    logic [CNT_W-1:0] n_count;

    logic [WB-1:0]    cap_eff;
    logic             issue;
    logic [WB:0]      fill_sum;
    logic [VAL_W:0]   val_sum;
    logic [VAL_W-1:0] val_sat;
    logic             full;
    logic             we;
    logic [BIN_W-1:0] wr_addr;
    logic [WB-1:0]    wr_fill;
    logic [VAL_W-1:0] wr_val;

    assign cap_eff  = r_cap[WB-1:0];
    assign issue    = i_cmd.scan && (r_rd_addr < r_count);
    assign fill_sum = {1'b0, r_rd_fill} + {1'b0, r_weight};
    assign val_sum  = {1'b0, r_rd_val} + (VAL_W+1)'(r_value);
    assign val_sat  = val_sum[VAL_W] ? ffbp_pkg::VALUE_MAX : val_sum[VAL_W-1:0];
    assign full     = (r_count == CNT_W'(MAX_BINS));

    assign o_stat.heavy     = r_heavy;
    assign o_stat.hit       = r_dv && (fill_sum <= {1'b0, cap_eff});
    assign o_stat.exhausted = !r_dv && (r_rd_addr >= r_count);

    // finish outcome: reject heavy, place on hit, reject full, else open a bin
    always_comb begin
        n_result = '0;
        n_count  = r_count;
        we       = 1'b0;
        wr_addr  = r_dv_idx;
        wr_fill  = fill_sum[WB-1:0];
        wr_val   = val_sat;
        if (r_heavy) begin
            n_result.place_status = ffbp_pkg::PLACE_TOO_HEAVY;
        end else if (o_stat.hit) begin
            we                       = 1'b1;
            n_result.place_status    = ffbp_pkg::PLACE_OK;
            n_result.bin_index       = ffbp_pkg::FIELD_W_INDEX'(r_dv_idx);
            n_result.bin_fill_after  = ffbp_pkg::FIELD_W_WEIGHT'(fill_sum[WB-1:0]);
            n_result.bin_value_after = val_sat;
        end else if (full) begin
            n_result.place_status = ffbp_pkg::PLACE_NO_BIN;
        end else begin
            we                       = 1'b1;
            wr_addr                  = r_count[BIN_W-1:0];
            wr_fill                  = r_weight;
            wr_val                   = VAL_W'(r_value);
            n_count                  = r_count + CNT_W'(1);
            n_result.place_status    = ffbp_pkg::PLACE_OK;
            n_result.bin_index       = ffbp_pkg::FIELD_W_INDEX'(r_count);
            n_result.opened_new_bin  = 1'b1;
            n_result.bin_fill_after  = ffbp_pkg::FIELD_W_WEIGHT'(r_weight);
            n_result.bin_value_after = VAL_W'(r_value);
        end
        n_result.bins_in_use = ffbp_pkg::FIELD_W_COUNT'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= ffbp_pkg::CAPACITY_RESET;
            r_count   <= '0;
            r_rd_addr <= '0;
            r_dv      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_rd_addr <= '0;
                r_dv      <= 1'b0;
                if (i_item.start_new_set) begin
                    r_count <= '0;
                end
            end else if (i_cmd.finish) begin
                r_dv    <= 1'b0;
                r_count <= n_count;
            end else if (i_cmd.scan) begin
                r_dv <= issue;
                if (issue) begin
                    r_rd_addr <= r_rd_addr + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_weight <= i_item.item_weight[WB-1:0];
            r_value  <= i_item.item_value;
            r_heavy  <= (i_item.item_weight[WB-1:0] > cap_eff);
        end
        if (issue) begin
            r_dv_idx <= r_rd_addr[BIN_W-1:0];
        end
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_fill <= fill_mem[r_rd_addr[BIN_W-1:0]];
            r_rd_val  <= val_mem[r_rd_addr[BIN_W-1:0]];
        end
        if (i_cmd.finish && we) begin
            fill_mem[wr_addr] <= wr_fill;
            val_mem[wr_addr]  <= wr_val;
        end
    end

    assign o_result = r_result;

endmodule

// ===== sv/first_fit_bin_packer_top.sv =====
// First-fit bin packer.
// Item channel: drive i_item and pulse i_start; the item is taken at an edge
// where i_start is high and o_busy is low. Each item yields exactly one
// result on o_result, shown for a single cycle while o_done is high; the
// receiver must take it then, it cannot stall the block.
// Config channel: i_cfg_valid / o_cfg_ready / i_cfg_data writes the bin
// capacity (Q8.8). Ready is always high; write only while o_busy is low.
// Flow: the item is taken, then the open bins are read from the
// fill/value memories one per cycle through a registered read port. The
// result is registered, with o_done, once a read bin fits the item (first
// fit), the open bins run out (a new bin opens unless all MAX_BINS are in
// use), or the item is too heavy; a too-heavy item needs no bin read. The
// scan of up to MAX_BINS bins is bound by the single memory read port.
// A new item can be accepted in the cycle o_done is high.
// Reset: capacity returns to 10.0 and the bin count to zero; no memory
// clearing pass is needed since only opened bins are ever read.
module first_fit_bin_packer_top #(
    parameter int MAX_BINS    = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ffbp_pkg::t_item   i_item,
    output logic              o_busy,
    output logic              o_done,
    output ffbp_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data
);

    ffbp_pkg::t_dp_cmd  cmd;
    ffbp_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    ffbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    ffbp_datapath #(
        .MAX_BINS    (MAX_BINS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_result   (o_result)
    );

endmodule
